FILE: design/tcsb_pkg.sv
// Shared types, codes and helpers for the tile column shift blitter.
`default_nettype none
package tcsb_pkg;

  localparam int DEF_MEM_WORDS = 8192;
  localparam int POS_W         = 13;
  localparam int WIDTH_W       = 10;
  localparam int WORD_W        = 32;
  localparam int COL_W         = 8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PLOT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_CAP,
    ST_CP_RD,
    ST_CP_WR,
    ST_RD_SRC,
    ST_RD_L,
    ST_WR_L,
    ST_WR_R,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0] rdata;
    logic              done;
  } res_t;

  // keeps the low rem nibbles; rem zero means a full column
  function automatic logic [WORD_W-1:0] low_mask(input logic [2:0] rem);
    logic [WORD_W-1:0] m;
    m = '1;
    if (rem != 3'd0) begin
      m = ~({WORD_W{1'b1}} << {rem, 2'b00});
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: design/tile_column_shift_blitter_unit.sv
// Top level of the tile column shift blitter: stream ports, result register, assertions.
//
//  channel | dir | tdata                                   | tuser
//  s_axis  | in  | address, data, width, src, stride, dest | opcode
//  m_axis  | out | read_data                               | op_done
//
// Write and read each make a single memory access. Plot copies each column row by row:
// a read and a write per row when the shift is zero, else a source read, two destination
// reads and two writes. The tile memory has a single read and a single write port.
// Reset clears control state only; memory contents stay undefined until written.
// A result waits in the output register while the next transfer is taken; a
// second result waits in the sequencer until that register drains.
`default_nettype none
module tile_column_shift_blitter_unit #(
  parameter int MEM_WORDS = tcsb_pkg::DEF_MEM_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // word_address[12:0] write_data[44:13] plot_width[54:45] source_pos[67:55]
  // source_stride[80:68] dest_pos[93:81], zero above
  input  wire logic [95:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[31:0]
  output      logic [31:0] m_axis_tdata,
  // op_done[0]
  output      logic [0:0]  m_axis_tuser
);
  import tcsb_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid;
  res_t              out_res;

  tcsb_seq #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .opcode        (op_t'(s_axis_tuser)),
    .word_address  (s_axis_tdata[12:0]),
    .write_data    (s_axis_tdata[44:13]),
    .plot_width    (s_axis_tdata[54:45]),
    .source_pos    (s_axis_tdata[67:55]),
    .source_stride (s_axis_tdata[80:68]),
    .dest_pos      (s_axis_tdata[93:81]),
    .mem_ctl       (mem_ctl),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  tcsb_mem #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_res.rdata;
  assign m_axis_tuser[0] = out_res.done;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  a_idle_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("unused opcode returned nonzero data");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.we && mem_ctl.re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write hit the same word");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !res_valid)
    else $error("sequencer ready while holding a result");
`endif

endmodule
`default_nettype wire

FILE: design/tcsb_mem.sv
// Tile word memory: one write port and one registered read port.
`default_nettype none
module tcsb_mem #(
  parameter int MEM_WORDS = tcsb_pkg::DEF_MEM_WORDS,
  parameter int AW        = $clog2(MEM_WORDS)
) (
  input  wire logic                        clk,
  input  wire tcsb_pkg::mem_ctl_t          ctl,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [tcsb_pkg::WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output      logic [tcsb_pkg::WORD_W-1:0] rdata
);
  import tcsb_pkg::*;

  logic [WORD_W-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/tcsb_merge.sv
// Shared shift and nibble-mask merge unit for the left and right destination words.
`default_nettype none
module tcsb_merge (
  input  wire logic [tcsb_pkg::WORD_W-1:0] old_word,
  input  wire logic [tcsb_pkg::WORD_W-1:0] px,
  input  wire logic [tcsb_pkg::WORD_W-1:0] mask,
  input  wire logic [2:0]                  shift,
  input  wire logic                        right,
  output      logic [tcsb_pkg::WORD_W-1:0] merged
);
  import tcsb_pkg::*;

  logic [5:0]          amt;
  logic [2*WORD_W-1:0] px_wide;
  logic [2*WORD_W-1:0] mask_wide;
  logic [WORD_W-1:0]   px_sel;
  logic [WORD_W-1:0]   mask_sel;

  // upper half of the 64-bit shift is the spill into the tile eight words on
  always_comb begin
    amt       = {1'b0, shift, 2'b00};
    px_wide   = {{WORD_W{1'b0}}, px} << amt;
    mask_wide = {{WORD_W{1'b0}}, mask} << amt;
    if (right) begin
      px_sel   = px_wide[2*WORD_W-1:WORD_W];
      mask_sel = mask_wide[2*WORD_W-1:WORD_W];
    end else begin
      px_sel   = px_wide[WORD_W-1:0];
      mask_sel = mask_wide[WORD_W-1:0];
    end
    merged = (old_word & ~mask_sel) | px_sel;
  end

endmodule
`default_nettype wire

FILE: design/tcsb_seq.sv
// Operation sequencer: address walk, row and column counters, memory and merge control.
`default_nettype none
module tcsb_seq #(
  parameter int MEM_WORDS = tcsb_pkg::DEF_MEM_WORDS,
  parameter int AW        = $clog2(MEM_WORDS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire tcsb_pkg::op_t                opcode,
  input  wire logic [tcsb_pkg::POS_W-1:0]   word_address,
  input  wire logic [tcsb_pkg::WORD_W-1:0]  write_data,
  input  wire logic [tcsb_pkg::WIDTH_W-1:0] plot_width,
  input  wire logic [tcsb_pkg::POS_W-1:0]   source_pos,
  input  wire logic [tcsb_pkg::POS_W-1:0]   source_stride,
  input  wire logic [tcsb_pkg::POS_W-1:0]   dest_pos,
  output      tcsb_pkg::mem_ctl_t           mem_ctl,
  output      logic [AW-1:0]                mem_waddr,
  output      logic [tcsb_pkg::WORD_W-1:0]  mem_wdata,
  output      logic [AW-1:0]                mem_raddr,
  input  wire logic [tcsb_pkg::WORD_W-1:0]  mem_rdata,
  output      logic                         res_valid,
  input  wire logic                         res_ready,
  output      tcsb_pkg::res_t               res
);
  import tcsb_pkg::*;

  localparam int EXT_W = (AW > POS_W) ? AW : POS_W;

  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     addr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     src;
  logic [AW-1:0]     dst;
  logic [AW-1:0]     stride;
  logic [2:0]        shift;
  logic [COL_W-1:0]  col_left;
  logic [2:0]        rem;
  logic [2:0]        row;
  logic [WORD_W-1:0] px;
  logic [WORD_W-1:0] res_rdata;
  logic              res_done;

  logic [EXT_W-1:0]  addr_ext;
  logic [EXT_W-1:0]  src_ext;
  logic [EXT_W-1:0]  dst_ext;
  logic [EXT_W-1:0]  stride_ext;
  logic [WIDTH_W:0]  width_up;
  logic [AW-1:0]     src_row;
  logic [AW-1:0]     dst_row;
  logic [AW-1:0]     dst_right;
  logic              row_last;
  logic              col_last;
  logic              accept;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] merged;

  assign addr_ext   = EXT_W'(word_address);
  assign src_ext    = EXT_W'({source_pos[POS_W-1:3], 3'b000});
  assign dst_ext    = EXT_W'({dest_pos[POS_W-1:3], 3'b000});
  assign stride_ext = EXT_W'(source_stride);
  assign width_up   = {1'b0, plot_width} + (WIDTH_W+1)'(7);
  assign src_row    = src + AW'(row);
  assign dst_row    = dst + AW'(row);
  assign dst_right  = dst_row + AW'(8);
  assign row_last   = (row == 3'd7);
  assign col_last   = (col_left == COL_W'(1));
  assign accept     = in_valid && in_ready;
  assign mask       = col_last ? low_mask(rem) : {WORD_W{1'b1}};
  assign res.rdata  = res_rdata;
  assign res.done   = res_done;

  tcsb_merge u_merge (
    .old_word (mem_rdata),
    .px       (px),
    .mask     (mask),
    .shift    (shift),
    .right    (state == ST_WR_R),
    .merged   (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_WRITE: state_next = ST_WRITE;
            OP_READ:  state_next = ST_READ;
            OP_PLOT: begin
              if (plot_width == '0) begin
                state_next = ST_DONE;
              end else if (dest_pos[2:0] == 3'd0) begin
                state_next = ST_CP_RD;
              end else begin
                state_next = ST_RD_SRC;
              end
            end
            OP_NONE:  state_next = ST_DONE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_WRITE:    state_next = ST_DONE;
      ST_READ:     state_next = ST_READ_CAP;
      ST_READ_CAP: state_next = ST_DONE;
      ST_CP_RD:    state_next = ST_CP_WR;
      ST_CP_WR: begin
        state_next = (row_last && col_last) ? ST_DONE : ST_CP_RD;
      end
      ST_RD_SRC:   state_next = ST_RD_L;
      ST_RD_L:     state_next = ST_WR_L;
      ST_WR_L:     state_next = ST_WR_R;
      ST_WR_R: begin
        state_next = (row_last && col_last) ? ST_DONE : ST_RD_SRC;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_ctl.we = 1'b0;
    mem_ctl.re = 1'b0;
    mem_waddr  = addr;
    mem_raddr  = addr;
    mem_wdata  = wdata;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_WRITE: mem_ctl.we = 1'b1;
      ST_READ:  mem_ctl.re = 1'b1;
      ST_CP_RD: begin
        mem_ctl.re = 1'b1;
        mem_raddr  = src_row;
      end
      ST_CP_WR: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = dst_row;
        mem_wdata  = mem_rdata;
      end
      ST_RD_SRC: begin
        mem_ctl.re = 1'b1;
        mem_raddr  = src_row;
      end
      ST_RD_L: begin
        mem_ctl.re = 1'b1;
        mem_raddr  = dst_row;
      end
      ST_WR_L: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = dst_row;
        mem_wdata  = merged;
        mem_ctl.re = 1'b1;
        mem_raddr  = dst_right;
      end
      ST_WR_R: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = dst_right;
        mem_wdata  = merged;
      end
      ST_DONE:  res_valid = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr      <= addr_ext[AW-1:0];
      wdata     <= write_data;
      src       <= src_ext[AW-1:0];
      dst       <= dst_ext[AW-1:0];
      stride    <= stride_ext[AW-1:0];
      shift     <= dest_pos[2:0];
      col_left  <= width_up[WIDTH_W:3];
      rem       <= plot_width[2:0];
      row       <= 3'd0;
      res_rdata <= '0;
      res_done  <= (opcode != OP_NONE);
    end else begin
      if (state == ST_RD_L) begin
        px <= mem_rdata & mask;
      end
      if (state == ST_READ_CAP) begin
        res_rdata <= mem_rdata;
      end
      if (state == ST_CP_WR || state == ST_WR_R) begin
        row <= row + 3'd1;
        if (row_last) begin
          src      <= src + stride;
          dst      <= dst + AW'(8);
          col_left <= col_left - COL_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the tile column shift blitter: word writes, reads and plots.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcsb_pkg::*;

  localparam int WORDS = DEF_MEM_WORDS;

  typedef struct {
    op_t         op;
    logic [12:0] addr;
    logic [31:0] wdata;
    logic [9:0]  width;
    logic [12:0] spos;
    logic [12:0] stride;
    logic [12:0] dpos;
  } blit_item_t;

  typedef struct {
    logic [31:0] rdata;
    logic        done;
  } blit_result_t;

  class blit_scoreboard;
    logic [31:0]  image [WORDS];
    blit_result_t due_q [$];
    int errors;
    int checked;
    int writes;
    int reads;
    int aligned_plots;
    int shifted_plots;
    int unused_ops;

    task report_mismatch(string msg);
      errors++;
      if (errors <= 30) begin
        $display("%0t ns mismatch: %s", $time, msg);
      end
    endtask

    function void blit(blit_item_t it);
      logic [12:0] src, dst, sa, la, ra;
      logic [31:0] mask, px;
      int unsigned lsl, lsr;
      int left;
      src = {it.spos[12:3], 3'b000};
      dst = {it.dpos[12:3], 3'b000};
      lsl = 4 * it.dpos[2:0];
      lsr = 32 - lsl;
      for (left = int'(it.width); left > 0; left -= 8) begin
        mask = '1;
        if (left < 8) begin
          mask = 32'hFFFF_FFFF >> (4 * (8 - left));
        end
        for (int row = 0; row < 8; row++) begin
          sa = src + 13'(row);
          la = dst + 13'(row);
          ra = dst + 13'(row) + 13'd8;
          if (lsl == 0) begin
            image[la] = image[sa];
          end else begin
            px = image[sa] & mask;
            image[la] = (image[la] & ~(mask << lsl)) | (px << lsl);
            image[ra] = (image[ra] & ~(mask >> lsr)) | (px >> lsr);
          end
        end
        src = src + it.stride;
        dst = dst + 13'd8;
      end
    endfunction

    function void note_item(blit_item_t it);
      blit_result_t r;
      r.rdata = '0;
      r.done  = 1'b1;
      case (it.op)
        OP_WRITE: begin
          image[it.addr] = it.wdata;
          writes++;
        end
        OP_READ: begin
          r.rdata = image[it.addr];
          reads++;
        end
        OP_PLOT: begin
          blit(it);
          if (it.dpos[2:0] == 3'd0) aligned_plots++;
          else shifted_plots++;
        end
        default: begin
          r.done = 1'b0;
          unused_ops++;
        end
      endcase
      due_q.push_back(r);
    endfunction

    task check_result(logic [31:0] rdata, logic done);
      blit_result_t e;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result rdata=%h done=%b", rdata, done));
        return;
      end
      e = due_q.pop_front();
      checked++;
      if (rdata !== e.rdata) begin
        report_mismatch($sformatf("read_data %h, expected %h", rdata, e.rdata));
      end
      if (done !== e.done) begin
        report_mismatch($sformatf("op_done %b, expected %b", done, e.done));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  blit_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [12:0] scene_base = '0;
  logic [12:0] last_dst = '0;
  int last_span = 8;

  tile_column_shift_blitter_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  function automatic blit_item_t mk(op_t op, int unsigned addr, int unsigned wdata = 0,
                                    int unsigned width = 0, int unsigned spos = 0,
                                    int unsigned stride = 0, int unsigned dpos = 0);
    blit_item_t it;
    it.op     = op;
    it.addr   = 13'(addr);
    it.wdata  = wdata;
    it.width  = 10'(width);
    it.spos   = 13'(spos);
    it.stride = 13'(stride);
    it.dpos   = 13'(dpos);
    return it;
  endfunction

  // reads lean on the last plotted region so plot results get observed
  function automatic blit_item_t random_item();
    blit_item_t it;
    int pick;
    it = mk(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      it.op = OP_NONE;
    end else if (pick < 5) begin
      it.op = op_t'($urandom_range(0, 3));
      it.width = 10'($urandom_range(0, 40));
    end else if (pick < 33) begin
      it.op = OP_WRITE;
      it.addr = scene_base + 13'($urandom_range(0, 255));
    end else if (pick < 63) begin
      it.op = OP_READ;
      if ($urandom_range(0, 9) < 7) it.addr = last_dst + 13'($urandom_range(0, last_span - 1));
      else it.addr = scene_base + 13'($urandom_range(0, 255));
    end else begin
      it.op = OP_PLOT;
      it.spos = scene_base + 13'($urandom_range(0, 255));
      it.dpos = scene_base + 13'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) it.dpos[2:0] = 3'd0;
      case ($urandom_range(0, 4))
        0: it.stride = 13'd8;
        1: it.stride = 13'd0;
        2: it.stride = 13'd16;
        3: it.stride = 13'($urandom_range(0, 63));
        default: it.stride = 13'($urandom);
      endcase
      if ($urandom_range(0, 99) == 0) it.width = 10'($urandom_range(0, 1023));
      else it.width = 10'($urandom_range(0, 40));
    end
    if (it.op == OP_PLOT) begin
      last_dst = {it.dpos[12:3], 3'b000};
      last_span = 8 * ((int'(it.width) + 7) / 8) + 8;
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task send_op(blit_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.dpos, it.stride, it.spos, it.width, it.wdata, it.addr};
    s_axis_tuser  <= it.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
  endtask

  task run_random(int count, int src_idle, int sink_stall);
    idle_pct  = src_idle;
    stall_pct = sink_stall;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) scene_base = 13'($urandom);
      if (i == count / 2 && src_idle == 0) drain();
      send_op(random_item());
    end
    drain();
  endtask

  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // every word gets a value before anything reads it: eight seeded tiles,
    // then aligned plots replicate them over the rest of the memory
    for (int a = 0; a < 64; a++) begin
      send_op(mk(OP_WRITE, a, $urandom));
    end
    for (int p = 0; p < 8; p++) begin
      send_op(mk(OP_PLOT, 0, 0, 1023, 0, 8, 64 + 1024 * p));
    end

    send_op(mk(OP_WRITE, 0, 32'h0000_0000));
    send_op(mk(OP_WRITE, 8191, 32'hFFFF_FFFF));
    send_op(mk(OP_READ, 8191));
    send_op(mk(OP_READ, 0));
    send_op(mk(OP_PLOT, 0, 0, 0, 40, 8, 133));
    send_op(mk(OP_READ, 128));
    send_op(mk(OP_PLOT, 0, 0, 8, 16, 8, 64));
    send_op(mk(OP_READ, 67));
    send_op(mk(OP_PLOT, 0, 0, 3, 200, 8, 256));
    send_op(mk(OP_READ, 263));
    send_op(mk(OP_PLOT, 0, 0, 1, 300, 8, 327));
    send_op(mk(OP_READ, 320));
    send_op(mk(OP_READ, 335));
    send_op(mk(OP_PLOT, 0, 0, 7, 400, 0, 513));
    send_op(mk(OP_READ, 519));
    // wraps past the top word
    send_op(mk(OP_PLOT, 0, 0, 16, 8190, 8191, 8191));
    send_op(mk(OP_READ, 3));
    send_op(mk(OP_READ, 12));
    // source and destination overlap
    send_op(mk(OP_PLOT, 0, 0, 24, 8, 8, 12));
    send_op(mk(OP_READ, 17));
    send_op(mk(OP_PLOT, 0, 0, 1023, 1000, 16, 3003));
    send_op(mk(OP_PLOT, 0, 0, 1023, 5000, 0, 6000));
    send_op(mk(OP_READ, 6500));
    send_op(mk(OP_NONE, 8191, 32'hFFFF_FFFF, 1023, 8191, 8191, 8191));
    send_op(mk(OP_READ, 4000));
    drain();

    run_random(300, 0, 0);
    run_random(300, 46, 0);
    run_random(300, 0, 46);
    run_random(300, 23, 23);

    repeat (40) @(posedge clk);
    if (sb.due_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.due_q.size()));
    end
    $display("ran %0d writes, %0d reads, %0d aligned and %0d shifted plots (fill included)",
             sb.writes, sb.reads, sb.aligned_plots, sb.shifted_plots);
    $display("%0d unused opcodes; %0d results compared under varied gaps and stalls, %0d mismatches",
             sb.unused_ops, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
